FILE: rtl/gse_pkg.sv
package gse_pkg;

  // geometry
  localparam int unsigned MAX_WIDTH = 2048;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned WEFF_W    = ($clog2(MAX_WIDTH + 1) > CFG_W) ?
                                      $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int unsigned MIN_DIM   = 3;
  localparam int unsigned WIN_EDGE  = 2;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  // pixel and gray conversion
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SUM_W   = 2 * PIX_W;
  localparam logic [PIX_W-1:0] COEF_B = PIX_W'(19);
  localparam logic [PIX_W-1:0] COEF_G = PIX_W'(183);
  localparam logic [PIX_W-1:0] COEF_R = PIX_W'(54);

  // one side of a gradient, up to four pixel weights
  localparam int unsigned ACC_W   = PIX_W + 2;

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic [COL_W-1:0] col;
    logic             prod;
    logic             eof;
  } q_entry_t;

endpackage

FILE: rtl/gse_stream_if.sv
interface gse_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface gse_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_res;
  logic       end_of_frame;

  modport source (output valid, output edge_res, output end_of_frame, input ready);
  modport sink   (input valid, input edge_res, input end_of_frame, output ready);
endinterface

FILE: rtl/gse_front.sv
module gse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  gse_pix_if.sink           pix_i,
  input  gse_pkg::geom_t    geom_i,
  input  logic              full_i,
  output logic              push_o,
  output gse_pkg::q_entry_t entry_o
);
  import gse_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [CFG_W-1:0]  row_q, row_d;
  logic [WEFF_W-1:0] w_raw, w_eff, c_ext;
  logic [CFG_W-1:0]  h_eff;
  logic [WEFF_W:0]   c_nxt;
  logic [CFG_W:0]    r_nxt;
  logic              col_wrap, row_wrap, accept;
  logic [SUM_W-1:0]  gray_sum;

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign push_o      = accept;

  // effective frame size
  always_comb begin
    w_raw = WEFF_W'(geom_i.width);
    if (w_raw < WEFF_W'(MIN_DIM)) begin
      w_eff = WEFF_W'(MIN_DIM);
    end else if (w_raw > WEFF_W'(MAX_WIDTH)) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (geom_i.height < CFG_W'(MIN_DIM)) begin
      h_eff = CFG_W'(MIN_DIM);
    end else begin
      h_eff = geom_i.height;
    end
  end

  assign c_ext    = WEFF_W'(col_q);
  assign c_nxt    = {1'b0, c_ext} + (WEFF_W+1)'(1);
  assign r_nxt    = {1'b0, row_q} + (CFG_W+1)'(1);
  assign col_wrap = c_nxt >= {1'b0, w_eff};
  assign row_wrap = r_nxt >= {1'b0, h_eff};

  assign gray_sum = SUM_W'(COEF_B) * SUM_W'(pix_i.blue)
                  + SUM_W'(COEF_G) * SUM_W'(pix_i.green)
                  + SUM_W'(COEF_R) * SUM_W'(pix_i.red);

  always_comb begin
    entry_o.gray = gray_sum[SUM_W-1 -: PIX_W];
    entry_o.col  = col_q;
    // interior window, inside the current bounds
    entry_o.prod = (c_ext < w_eff) && (row_q < h_eff) &&
                   (c_ext >= WEFF_W'(WIN_EDGE)) && (row_q >= CFG_W'(WIN_EDGE));
    entry_o.eof  = (c_nxt == {1'b0, w_eff}) && (r_nxt == {1'b0, h_eff});
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : r_nxt[CFG_W-1:0];
      end else begin
        col_d = c_nxt[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: rtl/gse_fifo.sv
module gse_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gse_pkg::q_entry_t entry_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output gse_pkg::q_entry_t head_o
);
  import gse_pkg::*;

  q_entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == (QPTR_W+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/gse_back.sv
module gse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  gse_pkg::q_entry_t q_head_i,
  output logic              q_pop_o,
  gse_res_if.source         res_o
);
  import gse_pkg::*;

  logic [PIX_W-1:0] older_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  q_entry_t         s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic [PIX_W-1:0] top_rd_q, mid_rd_q;
  logic [PIX_W-1:0] win_q [6];
  logic             exec;

  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_res_q;
  logic             out_eof_q;

  logic [ACC_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
  logic [ACC_W:0]   mag;
  logic [PIX_W-1:0] mag_sat;

  // an item that yields no result never waits on the output side
  assign exec    = s1_valid_q && (!s1_q.prod || !out_valid_q || res_o.ready);
  assign q_pop_o = q_valid_i && (!s1_valid_q || exec);

  // line stores: read at pop, written back when the item executes
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      top_rd_q <= older_mem[q_head_i.col];
      mid_rd_q <= middle_mem[q_head_i.col];
    end
    if (exec) begin
      older_mem[s1_q.col]  <= mid_rd_q;
      middle_mem[s1_q.col] <= s1_q.gray;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_head_i;
    end
  end

  // window: p1 p4 p7 = cells 0..2 (column c-2), p2 p5 p8 = cells 3..5
  always_comb begin
    gx_pos = ACC_W'(top_rd_q) + {1'b0, mid_rd_q, 1'b0} + ACC_W'(s1_q.gray);
    gx_neg = ACC_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + ACC_W'(win_q[2]);
    gy_pos = ACC_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + ACC_W'(top_rd_q);
    gy_neg = ACC_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + ACC_W'(s1_q.gray);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = {1'b0, gx_abs} + {1'b0, gy_abs};
    mag_sat = (mag > (ACC_W+1)'(255)) ? '1 : mag[PIX_W-1:0];
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (q_pop_o) begin
      s1_valid_d = 1'b1;
    end else if (exec) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec && s1_q.prod) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top_rd_q;
        win_q[4] <= mid_rd_q;
        win_q[5] <= s1_q.gray;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && s1_q.prod) begin
      out_res_q <= mag_sat;
      out_eof_q <= s1_q.eof;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.edge_res     = out_res_q;
  assign res_o.end_of_frame = out_eof_q;

endmodule

FILE: rtl/gray_sobel_edge_stream_unit.sv
// channel   dir  handshake          payload
// pix_i     in   valid/ready        blue, green, red (8 bit each)
// res_o     out  valid/ready        edge_res (8 bit), end_of_frame
// apb       in   psel/penable       frame_width @0x0, frame_height @0x4
//
// one pixel per clock while the queue is not full; a result passes these steps
// (front stage into the queue, line store read, sobel into the output register)
// reset clears counters, window and queue; line stores are not cleared
// a stalled output holds the back stage; the queue keeps the input taking
// pixels until it fills, and pixels without a result drain past a stall
module gray_sobel_edge_stream_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gse_pix_if.sink                    pix_i,
  gse_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gse_pkg::APB_AW-1:0] paddr,
  input  logic [gse_pkg::APB_DW-1:0] pwdata,
  output logic [gse_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import gse_pkg::*;

  geom_t    geom_q, geom_d;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     push, full, q_valid, q_pop;
  q_entry_t entry, q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    geom_d = geom_q;
    prdata = '0;
    unique case (reg_idx)
      REG_FRAME_WIDTH: begin
        prdata = APB_DW'(geom_q.width);
        if (cfg_wr) begin
          geom_d.width = pwdata[CFG_W-1:0];
        end
      end
      REG_FRAME_HEIGHT: begin
        prdata = APB_DW'(geom_q.height);
        if (cfg_wr) begin
          geom_d.height = pwdata[CFG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.width  <= WIDTH_RST;
      geom_q.height <= HEIGHT_RST;
    end else begin
      geom_q <= geom_d;
    end
  end

  gse_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_i),
    .geom_i  (geom_q),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  gse_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (q_pop),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  gse_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule
